// ----- rtl/rbcb_pkg.sv -----
// Package for the retry backoff circuit breaker.
// Holds widths, command and action codes, register indexes and shared types.
// No dependencies.
package rbcb_pkg;

  localparam int CMD_W    = 2;
  localparam int JIT_W    = 6;
  localparam int ACT_W    = 3;
  localparam int DELAY_W  = 21;
  localparam int ATT_W    = 4;
  localparam int TALLY_W  = 6;
  localparam int TRIES_W  = 4;
  localparam int BASE_W   = 16;
  localparam int CEIL_W   = 20;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;

  localparam int EXPO_W   = BASE_W + (1 << ATT_W) - 1;
  localparam int MAG_W    = JIT_W;
  localparam int PROD_W   = CEIL_W + MAG_W;
  localparam int RECIP_W  = 26;
  localparam int RECIP_SH = 32;
  localparam int QUOT_W   = 19;

  localparam int JITTER_PERCENT = 20;
  localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(63);

  // Reciprocal of 100 scaled by 2**32, rounded up; exact for products below 2**30.
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(42949673);

  localparam logic [TRIES_W-1:0] MAX_TRIES_RST  = TRIES_W'(3);
  localparam logic [BASE_W-1:0]  BASE_DELAY_RST = BASE_W'(100);
  localparam logic [CEIL_W-1:0]  CEILING_RST    = CEIL_W'(10000);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING    = CFG_IDX_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_OUTCOME = 2'd1,
    CMD_RESET   = 2'd2
  } cmd_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_ATTEMPT    = 3'd0,
    ACT_WAIT       = 3'd1,
    ACT_SUCCEEDED  = 3'd2,
    ACT_FAILED     = 3'd3,
    ACT_REJECTED   = 3'd4,
    ACT_IGNORED    = 3'd5,
    ACT_RESET_DONE = 3'd6
  } action_t;

  typedef struct packed {
    action_t          action;
    logic             breaker_open;
    logic [ATT_W-1:0] attempt_number;
    logic             retry;
  } ctl_res_t;

  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } stg_en_t;

endpackage

// ----- rtl/rbcb_if.sv -----
// Channel interfaces for the retry backoff circuit breaker.
// Depends on rbcb_pkg for the field widths.
interface rbcb_in_if;
  logic                                valid;
  logic                                ready;
  logic [rbcb_pkg::CMD_W-1:0]          cmd;
  logic                                success;
  logic signed [rbcb_pkg::JIT_W-1:0]   jitter_sample;
  modport source (output valid, cmd, success, jitter_sample, input ready);
  modport sink   (input valid, cmd, success, jitter_sample, output ready);
endinterface

interface rbcb_out_if;
  logic                               valid;
  logic                               ready;
  logic [rbcb_pkg::ACT_W-1:0]         action;
  logic [rbcb_pkg::DELAY_W-1:0]       wait_ms;
  logic                               breaker_open;
  logic [rbcb_pkg::ATT_W-1:0]         attempt_number;
  modport source (output valid, action, wait_ms, breaker_open, attempt_number, input ready);
  modport sink   (input valid, action, wait_ms, breaker_open, attempt_number, output ready);
endinterface

// ----- rtl/rbcb_ctrl.sv -----
// Retry and breaker control state with the per-item decision logic.
// Depends on rbcb_pkg for codes and the result struct.
module rbcb_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [rbcb_pkg::CMD_W-1:0]    cmd,
  input  logic                          success,
  input  logic [rbcb_pkg::TRIES_W-1:0]  max_tries,
  output rbcb_pkg::ctl_res_t            res
);

  logic                            tripped_r, tripped_nxt;
  logic [rbcb_pkg::TALLY_W-1:0]    tally_r, tally_nxt;
  logic [rbcb_pkg::ATT_W-1:0]      attempt_r, attempt_nxt;
  logic                            active_r, active_nxt;

  logic [rbcb_pkg::TRIES_W-1:0]    limit;
  logic [rbcb_pkg::ATT_W:0]        next_att;
  logic [rbcb_pkg::TALLY_W-1:0]    tally_inc;
  rbcb_pkg::action_t               action;
  logic                            retry;

  assign limit     = (max_tries == '0) ? rbcb_pkg::TRIES_W'(1) : max_tries;
  assign next_att  = {1'b0, attempt_r} + (rbcb_pkg::ATT_W+1)'(1);
  assign tally_inc = (tally_r < rbcb_pkg::TALLY_MAX) ? tally_r + rbcb_pkg::TALLY_W'(1) : tally_r;

  always_comb begin
    tripped_nxt = tripped_r;
    tally_nxt   = tally_r;
    attempt_nxt = attempt_r;
    active_nxt  = active_r;
    action      = rbcb_pkg::ACT_IGNORED;
    retry       = 1'b0;
    unique case (rbcb_pkg::cmd_t'(cmd))
      rbcb_pkg::CMD_START: begin
        if (tripped_r) begin
          action = rbcb_pkg::ACT_REJECTED;
        end else if (!active_r) begin
          active_nxt  = 1'b1;
          attempt_nxt = '0;
          action      = rbcb_pkg::ACT_ATTEMPT;
        end
      end
      rbcb_pkg::CMD_OUTCOME: begin
        if (active_r) begin
          if (success) begin
            tally_nxt   = '0;
            tripped_nxt = 1'b0;
            active_nxt  = 1'b0;
            attempt_nxt = '0;
            action      = rbcb_pkg::ACT_SUCCEEDED;
          end else begin
            tally_nxt = tally_inc;
            if (next_att < {1'b0, limit}) begin
              attempt_nxt = next_att[rbcb_pkg::ATT_W-1:0];
              action      = rbcb_pkg::ACT_WAIT;
              retry       = 1'b1;
            end else begin
              if (tally_inc >= {1'b0, limit, 1'b0}) begin
                tripped_nxt = 1'b1;
              end
              active_nxt  = 1'b0;
              attempt_nxt = '0;
              action      = rbcb_pkg::ACT_FAILED;
            end
          end
        end
      end
      rbcb_pkg::CMD_RESET: begin
        tally_nxt   = '0;
        tripped_nxt = 1'b0;
        action      = rbcb_pkg::ACT_RESET_DONE;
      end
      default: begin
        action = rbcb_pkg::ACT_IGNORED;
      end
    endcase
  end

  always_comb begin
    res.action         = action;
    res.breaker_open   = tripped_nxt;
    res.attempt_number = attempt_nxt;
    res.retry          = retry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tripped_r <= 1'b0;
      tally_r   <= '0;
      attempt_r <= '0;
      active_r  <= 1'b0;
    end else if (fire) begin
      tripped_r <= tripped_nxt;
      tally_r   <= tally_nxt;
      attempt_r <= attempt_nxt;
      active_r  <= active_nxt;
    end
  end

endmodule

// ----- rtl/rbcb_delay.sv -----
// Backoff delay pipeline: capped exponential delay, jitter product, divide by 100.
// Depends on rbcb_pkg for widths, constants and the stage enable struct.
module rbcb_delay (
  input  logic                               clk,
  input  rbcb_pkg::stg_en_t                  en,
  input  logic                               retry,
  input  logic [rbcb_pkg::ATT_W-1:0]         attempt,
  input  logic signed [rbcb_pkg::JIT_W-1:0]  jitter,
  input  logic [rbcb_pkg::BASE_W-1:0]        base_delay,
  input  logic [rbcb_pkg::CEIL_W-1:0]        delay_ceiling,
  output logic [rbcb_pkg::DELAY_W-1:0]       wait_ms
);

  localparam logic [rbcb_pkg::JIT_W:0] JP = (rbcb_pkg::JIT_W+1)'(rbcb_pkg::JITTER_PERCENT);
  localparam int FULL_W = rbcb_pkg::PROD_W + rbcb_pkg::RECIP_W;

  logic [rbcb_pkg::EXPO_W-1:0]  expo;
  logic [rbcb_pkg::CEIL_W-1:0]  capped;
  logic [rbcb_pkg::JIT_W:0]     jit_abs;
  logic [rbcb_pkg::MAG_W-1:0]   mag;
  logic [FULL_W-1:0]            full;

  logic [rbcb_pkg::CEIL_W-1:0]  cap2_r, cap3_r, cap4_r;
  logic [rbcb_pkg::MAG_W-1:0]   mag2_r;
  logic                         neg2_r, neg3_r, neg4_r;
  logic [rbcb_pkg::PROD_W-1:0]  prod3_r;
  logic [rbcb_pkg::QUOT_W-1:0]  quot4_r;
  logic [rbcb_pkg::DELAY_W-1:0] delay5_r, delay5_nxt;

  assign expo    = rbcb_pkg::EXPO_W'(base_delay) << attempt;
  assign capped  = !retry ? '0 :
                   (expo < rbcb_pkg::EXPO_W'(delay_ceiling)) ?
                   expo[rbcb_pkg::CEIL_W-1:0] : delay_ceiling;
  assign jit_abs = jitter[rbcb_pkg::JIT_W-1] ? -{jitter[rbcb_pkg::JIT_W-1], jitter}
                                             : {1'b0, jitter};
  assign mag     = (jit_abs > JP) ? JP[rbcb_pkg::MAG_W-1:0] : jit_abs[rbcb_pkg::MAG_W-1:0];
  assign full    = FULL_W'(prod3_r) * FULL_W'(rbcb_pkg::RECIP_100);

  assign delay5_nxt = neg4_r ? rbcb_pkg::DELAY_W'(cap4_r) - rbcb_pkg::DELAY_W'(quot4_r)
                             : rbcb_pkg::DELAY_W'(cap4_r) + rbcb_pkg::DELAY_W'(quot4_r);

  always_ff @(posedge clk) begin
    if (en.en2) begin
      cap2_r <= capped;
      mag2_r <= mag;
      neg2_r <= jitter[rbcb_pkg::JIT_W-1];
    end
    if (en.en3) begin
      cap3_r  <= cap2_r;
      neg3_r  <= neg2_r;
      prod3_r <= rbcb_pkg::PROD_W'(cap2_r) * rbcb_pkg::PROD_W'(mag2_r);
    end
    if (en.en4) begin
      cap4_r  <= cap3_r;
      neg4_r  <= neg3_r;
      quot4_r <= full[rbcb_pkg::RECIP_SH +: rbcb_pkg::QUOT_W];
    end
    if (en.en5) begin
      delay5_r <= delay5_nxt;
    end
  end

  assign wait_ms = delay5_r;

endmodule

// ----- rtl/retry_backoff_circuit_breaker.sv -----
// Retry sequencer with a circuit breaker and exponential backoff with jitter.
// Takes one item per clock while the output is not stalled and returns one result per
// item, in order, through five register stages: the retry and breaker state is updated
// as each item leaves the first stage, so consecutive items follow without gaps, while
// the delay arithmetic runs alongside (capped shift, then jitter product, divide by 100
// and add in three further stages). Each stage holds its item when the output is stalled,
// and the input keeps accepting until every stage is full. Config takes effect for items
// leaving the first stage after the write; write it only while the block is idle.
// Depends on rbcb_pkg, rbcb_if, rbcb_ctrl and rbcb_delay.
module retry_backoff_circuit_breaker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rbcb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbcb_pkg::CFG_W-1:0]       cfg_wdata,
  rbcb_in_if.sink                          in_itm,
  rbcb_out_if.source                       out_itm
);

  logic [rbcb_pkg::TRIES_W-1:0] max_tries_r;
  logic [rbcb_pkg::BASE_W-1:0]  base_delay_r;
  logic [rbcb_pkg::CEIL_W-1:0]  ceiling_r;

  logic                              v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                              adv1, adv2, adv3, adv4, adv5;
  logic [rbcb_pkg::CMD_W-1:0]        cmd1_r;
  logic                              suc1_r;
  logic signed [rbcb_pkg::JIT_W-1:0] jit1_r;

  rbcb_pkg::ctl_res_t ctl_res;
  rbcb_pkg::ctl_res_t ctl2_r, ctl3_r, ctl4_r, ctl5_r;
  rbcb_pkg::stg_en_t  stg_en;

  assign adv5 = !v5_r || out_itm.ready;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_itm.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tries_r  <= rbcb_pkg::MAX_TRIES_RST;
      base_delay_r <= rbcb_pkg::BASE_DELAY_RST;
      ceiling_r    <= rbcb_pkg::CEILING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbcb_pkg::CFG_MAX_TRIES:  max_tries_r  <= cfg_wdata[rbcb_pkg::TRIES_W-1:0];
        rbcb_pkg::CFG_BASE_DELAY: base_delay_r <= cfg_wdata[rbcb_pkg::BASE_W-1:0];
        rbcb_pkg::CFG_CEILING:    ceiling_r    <= cfg_wdata[rbcb_pkg::CEIL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_itm.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      cmd1_r <= in_itm.cmd;
      suc1_r <= in_itm.success;
      jit1_r <= in_itm.jitter_sample;
    end
    if (adv2) ctl2_r <= ctl_res;
    if (adv3) ctl3_r <= ctl2_r;
    if (adv4) ctl4_r <= ctl3_r;
    if (adv5) ctl5_r <= ctl4_r;
  end

  rbcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (adv2 && v1_r),
    .cmd       (cmd1_r),
    .success   (suc1_r),
    .max_tries (max_tries_r),
    .res       (ctl_res)
  );

  always_comb begin
    stg_en.en2 = adv2;
    stg_en.en3 = adv3;
    stg_en.en4 = adv4;
    stg_en.en5 = adv5;
  end

  rbcb_delay u_delay (
    .clk           (clk),
    .en            (stg_en),
    .retry         (ctl_res.retry),
    .attempt       (ctl_res.attempt_number),
    .jitter        (jit1_r),
    .base_delay    (base_delay_r),
    .delay_ceiling (ceiling_r),
    .wait_ms       (out_itm.wait_ms)
  );

  assign out_itm.valid          = v5_r;
  assign out_itm.action         = ctl5_r.action;
  assign out_itm.breaker_open   = ctl5_r.breaker_open;
  assign out_itm.attempt_number = ctl5_r.attempt_number;

endmodule

// ----- test/tb_retry_backoff_circuit_breaker.sv -----
// Testbench for retry_backoff_circuit_breaker: directed table, then random request traffic
// under several register settings, with bursty input and a stalling output.
// Depends on rbcb_pkg, rbcb_if and the block's RTL.
`timescale 1ns / 1ps

module tb_retry_backoff_circuit_breaker;

  localparam logic [rbcb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int N_DIR = 25;

  typedef struct packed {
    rbcb_pkg::action_t              action;
    logic [rbcb_pkg::DELAY_W-1:0]   delay;
    logic                           brk;
    logic [rbcb_pkg::ATT_W-1:0]     att;
  } result_t;

  typedef struct packed {
    logic [rbcb_pkg::CMD_W-1:0]        cmd;
    logic                              ok;
    logic signed [rbcb_pkg::JIT_W-1:0] jit;
    logic                              fixed;
    result_t                           want;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rbcb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rbcb_pkg::CFG_W-1:0] cfg_wdata;

  rbcb_in_if in_ch ();
  rbcb_out_if out_ch ();

  retry_backoff_circuit_breaker u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_itm    (in_ch),
    .out_itm   (out_ch)
  );

  // Shadow of the register file and of the sequencer state.
  logic [rbcb_pkg::TRIES_W-1:0] cfg_tries;
  logic [rbcb_pkg::BASE_W-1:0]  cfg_base;
  logic [rbcb_pkg::CEIL_W-1:0]  cfg_ceil;
  logic                         brk_open;
  logic [rbcb_pkg::TALLY_W-1:0] fail_tally;
  logic [rbcb_pkg::ATT_W-1:0]   att_idx;
  logic                         req_busy;

  result_t pending_results[$];
  int mismatches = 0;
  int burst_left;
  bit gaps_on;
  int rx_cycle = 0;
  int stall_mode = 0;

  row_t dir_rows [N_DIR] = '{
    '{rbcb_pkg::CMD_OUTCOME, 1'b1, 6'sd0,   1'b1, '{rbcb_pkg::ACT_IGNORED, 21'd0, 1'b0, 4'd0}},
    '{CMD_UNUSED,            1'b1, 6'sh20,  1'b1, '{rbcb_pkg::ACT_IGNORED, 21'd0, 1'b0, 4'd0}},
    '{rbcb_pkg::CMD_START,   1'b0, 6'sd31,  1'b1, '{rbcb_pkg::ACT_ATTEMPT, 21'd0, 1'b0, 4'd0}},
    '{rbcb_pkg::CMD_START,   1'b1, 6'sd0,   1'b1, '{rbcb_pkg::ACT_IGNORED, 21'd0, 1'b0, 4'd0}},
    '{rbcb_pkg::CMD_OUTCOME, 1'b0, 6'sd0,   1'b0, '0},
    '{rbcb_pkg::CMD_OUTCOME, 1'b0, 6'sd20,  1'b0, '0},
    '{rbcb_pkg::CMD_OUTCOME, 1'b0, -6'sd20, 1'b1, '{rbcb_pkg::ACT_FAILED, 21'd0, 1'b0, 4'd0}},
    '{rbcb_pkg::CMD_START,   1'b0, 6'sd0,   1'b1, '{rbcb_pkg::ACT_ATTEMPT, 21'd0, 1'b0, 4'd0}},
    '{rbcb_pkg::CMD_OUTCOME, 1'b0, 6'sd31,  1'b0, '0},
    '{rbcb_pkg::CMD_RESET,   1'b0, 6'sd0,   1'b1,
      '{rbcb_pkg::ACT_RESET_DONE, 21'd0, 1'b0, 4'd1}},
    '{rbcb_pkg::CMD_OUTCOME, 1'b0, 6'sh20,  1'b0, '0},
    '{rbcb_pkg::CMD_OUTCOME, 1'b0, 6'sd5,   1'b1, '{rbcb_pkg::ACT_FAILED, 21'd0, 1'b0, 4'd0}},
    '{rbcb_pkg::CMD_START,   1'b0, 6'sd0,   1'b1, '{rbcb_pkg::ACT_ATTEMPT, 21'd0, 1'b0, 4'd0}},
    '{rbcb_pkg::CMD_OUTCOME, 1'b1, 6'sd0,   1'b1,
      '{rbcb_pkg::ACT_SUCCEEDED, 21'd0, 1'b0, 4'd0}},
    '{rbcb_pkg::CMD_START,   1'b0, 6'sd0,   1'b1, '{rbcb_pkg::ACT_ATTEMPT, 21'd0, 1'b0, 4'd0}},
    '{rbcb_pkg::CMD_OUTCOME, 1'b0, -6'sd1,  1'b0, '0},
    '{rbcb_pkg::CMD_OUTCOME, 1'b0, 6'sd19,  1'b0, '0},
    '{rbcb_pkg::CMD_OUTCOME, 1'b0, 6'sd0,   1'b1, '{rbcb_pkg::ACT_FAILED, 21'd0, 1'b0, 4'd0}},
    '{rbcb_pkg::CMD_START,   1'b0, 6'sd0,   1'b1, '{rbcb_pkg::ACT_ATTEMPT, 21'd0, 1'b0, 4'd0}},
    '{rbcb_pkg::CMD_OUTCOME, 1'b0, -6'sd19, 1'b0, '0},
    '{rbcb_pkg::CMD_OUTCOME, 1'b0, 6'sd10,  1'b0, '0},
    '{rbcb_pkg::CMD_OUTCOME, 1'b0, 6'sd0,   1'b1, '{rbcb_pkg::ACT_FAILED, 21'd0, 1'b1, 4'd0}},
    '{rbcb_pkg::CMD_START,   1'b0, 6'sd0,   1'b1,
      '{rbcb_pkg::ACT_REJECTED, 21'd0, 1'b1, 4'd0}},
    '{rbcb_pkg::CMD_OUTCOME, 1'b1, 6'sd0,   1'b1, '{rbcb_pkg::ACT_IGNORED, 21'd0, 1'b1, 4'd0}},
    '{rbcb_pkg::CMD_RESET,   1'b0, 6'sd0,   1'b1,
      '{rbcb_pkg::ACT_RESET_DONE, 21'd0, 1'b0, 4'd0}}
  };

  function automatic logic [rbcb_pkg::DELAY_W-1:0] backoff(
      logic [rbcb_pkg::ATT_W-1:0] n, logic signed [rbcb_pkg::JIT_W-1:0] jit);
    logic [63:0] expo;
    logic [63:0] capped;
    logic [63:0] part;
    logic [63:0] total;
    int j;
    expo = 64'(cfg_base) << n;
    capped = (expo < 64'(cfg_ceil)) ? expo : 64'(cfg_ceil);
    j = jit;
    if (j > rbcb_pkg::JITTER_PERCENT) j = rbcb_pkg::JITTER_PERCENT;
    if (j < -rbcb_pkg::JITTER_PERCENT) j = -rbcb_pkg::JITTER_PERCENT;
    part = (capped * 64'((j < 0) ? -j : j)) / 64'd100;
    total = (j < 0) ? capped - part : capped + part;
    return total[rbcb_pkg::DELAY_W-1:0];
  endfunction

  function automatic result_t next_action(logic [rbcb_pkg::CMD_W-1:0] cmd, logic ok,
                                          logic signed [rbcb_pkg::JIT_W-1:0] jit);
    result_t r;
    logic [4:0] tries;
    logic [4:0] nxt;
    r = '{rbcb_pkg::ACT_IGNORED, '0, 1'b0, '0};
    tries = (cfg_tries == '0) ? 5'd1 : {1'b0, cfg_tries};
    case (cmd)
      rbcb_pkg::CMD_START: begin
        if (brk_open) begin
          r.action = rbcb_pkg::ACT_REJECTED;
        end else if (!req_busy) begin
          req_busy = 1'b1;
          att_idx = '0;
          r.action = rbcb_pkg::ACT_ATTEMPT;
        end
      end
      rbcb_pkg::CMD_OUTCOME: begin
        if (req_busy && ok) begin
          fail_tally = '0;
          brk_open = 1'b0;
          req_busy = 1'b0;
          att_idx = '0;
          r.action = rbcb_pkg::ACT_SUCCEEDED;
        end else if (req_busy) begin
          nxt = {1'b0, att_idx} + 5'd1;
          if (fail_tally != rbcb_pkg::TALLY_MAX) fail_tally = fail_tally + 1'b1;
          if (nxt < tries) begin
            att_idx = nxt[rbcb_pkg::ATT_W-1:0];
            r.delay = backoff(nxt[rbcb_pkg::ATT_W-1:0], jit);
            r.action = rbcb_pkg::ACT_WAIT;
          end else begin
            if (7'(fail_tally) >= 7'(tries) * 7'd2) brk_open = 1'b1;
            req_busy = 1'b0;
            att_idx = '0;
            r.action = rbcb_pkg::ACT_FAILED;
          end
        end
      end
      rbcb_pkg::CMD_RESET: begin
        fail_tally = '0;
        brk_open = 1'b0;
        r.action = rbcb_pkg::ACT_RESET_DONE;
      end
      default: ;
    endcase
    r.brk = brk_open;
    r.att = att_idx;
    return r;
  endfunction

  task automatic drive_item(logic [rbcb_pkg::CMD_W-1:0] cmd, logic ok,
                            logic signed [rbcb_pkg::JIT_W-1:0] jit,
                            logic fixed, result_t want);
    int gap;
    result_t r;
    if (gaps_on && burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.success <= ok;
    in_ch.jitter_sample <= jit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = next_action(cmd, ok, jit);
    pending_results.push_back(fixed ? want : r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_config(logic [rbcb_pkg::TRIES_W-1:0] tries,
                            logic [rbcb_pkg::BASE_W-1:0] base,
                            logic [rbcb_pkg::CEIL_W-1:0] ceil);
    logic [rbcb_pkg::CFG_W-1:0] junk;
    junk = $urandom;
    cfg_we <= 1'b1;
    cfg_index <= rbcb_pkg::CFG_MAX_TRIES;
    cfg_wdata <= {junk[rbcb_pkg::CFG_W-1:rbcb_pkg::TRIES_W], tries};
    @(posedge clk);
    cfg_index <= rbcb_pkg::CFG_BASE_DELAY;
    cfg_wdata <= {junk[rbcb_pkg::CFG_W-1:rbcb_pkg::BASE_W], base};
    @(posedge clk);
    cfg_index <= rbcb_pkg::CFG_CEILING;
    cfg_wdata <= ceil;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_tries = tries;
    cfg_base = base;
    cfg_ceil = ceil;
  endtask

  // Mostly well-formed requests: a start followed by outcomes, with some noise.
  task automatic run_requests(int n);
    int pick;
    logic [rbcb_pkg::CMD_W-1:0] cmd;
    logic ok;
    logic signed [rbcb_pkg::JIT_W-1:0] jit;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (req_busy) begin
        cmd = (pick < 82) ? rbcb_pkg::CMD_OUTCOME : (pick < 88) ? rbcb_pkg::CMD_START :
              (pick < 94) ? rbcb_pkg::CMD_RESET : CMD_UNUSED;
      end else if (brk_open) begin
        cmd = (pick < 40) ? rbcb_pkg::CMD_START : (pick < 80) ? rbcb_pkg::CMD_RESET :
              (pick < 90) ? rbcb_pkg::CMD_OUTCOME : CMD_UNUSED;
      end else begin
        cmd = (pick < 65) ? rbcb_pkg::CMD_START : (pick < 75) ? rbcb_pkg::CMD_RESET :
              (pick < 87) ? rbcb_pkg::CMD_OUTCOME : CMD_UNUSED;
      end
      ok = (cmd == rbcb_pkg::CMD_OUTCOME) ? ($urandom_range(0, 99) < 20) : 1'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        jit = rbcb_pkg::JIT_W'($signed($urandom_range(0, 40)) - 20);
      end else begin
        jit = rbcb_pkg::JIT_W'($urandom_range(0, 63));
      end
      drive_item(cmd, ok, jit, 1'b0, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{rbcb_pkg::action_t'(out_ch.action), out_ch.wait_ms, out_ch.breaker_open,
              out_ch.attempt_number};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result action=%0d delay=%0d open=%0d attempt=%0d",
                   $time, got.action, got.delay, got.brk, got.att);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.action !== want.action || got.delay !== want.delay ||
            got.brk !== want.brk || got.att !== want.att) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected action=%0d delay=%0d open=%0d attempt=%0d", $time,
                     want.action, want.delay, want.brk, want.att);
            $display("%0t: got      action=%0d delay=%0d open=%0d attempt=%0d", $time,
                     got.action, got.delay, got.brk, got.att);
          end
        end
      end
    end
    if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom);
      2: out_ch.ready <= (rx_cycle % 4 == 0);
      default: out_ch.ready <= (rx_cycle % 16 >= 10);
    endcase
    rx_cycle++;
  end

  initial begin
    burst_left = 0;
    gaps_on = 1'b1;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= '0;
    in_ch.success <= 1'b0;
    in_ch.jitter_sample <= '0;
    cfg_tries = rbcb_pkg::MAX_TRIES_RST;
    cfg_base = rbcb_pkg::BASE_DELAY_RST;
    cfg_ceil = rbcb_pkg::CEILING_RST;
    brk_open = 1'b0;
    fail_tally = '0;
    att_idx = '0;
    req_busy = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      drive_item(dir_rows[i].cmd, dir_rows[i].ok, dir_rows[i].jit, dir_rows[i].fixed,
                 dir_rows[i].want);
    end

    for (int p = 0; p < 7; p++) begin
      drain();
      case (p)
        0: set_config(4'd0, 16'd0, 20'd0);
        1: set_config(4'd15, 16'hFFFF, 20'hFFFFF);
        2: set_config(4'd1, 16'd1, 20'd0);
        3: set_config(4'd15, 16'd1, 20'hFFFFF);
        4: set_config(rbcb_pkg::MAX_TRIES_RST, rbcb_pkg::BASE_DELAY_RST,
                      rbcb_pkg::CEILING_RST);
        default: set_config(rbcb_pkg::TRIES_W'($urandom), rbcb_pkg::BASE_W'($urandom),
                            rbcb_pkg::CEIL_W'($urandom));
      endcase
      gaps_on = (p != 2);
      run_requests(130);
    end

    drain();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rbcb_pkg.sv
rtl/rbcb_if.sv
rtl/rbcb_ctrl.sv
rtl/rbcb_delay.sv
rtl/retry_backoff_circuit_breaker.sv
test/tb_retry_backoff_circuit_breaker.sv
